FILE: src/acp_pkg.sv
// Shared constants and types of the accumulator processor core.
package acp_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_PAD_W  = 6;
  localparam int COUNT_W    = 48;

  localparam logic [15:0] STACK_RESET = 16'hFFFE;

  localparam logic [7:0] OP_LDI = 8'h10;
  localparam logic [7:0] OP_ADD = 8'h20;
  localparam logic [7:0] OP_SUB = 8'h21;
  localparam logic [7:0] OP_STA = 8'h30;
  localparam logic [7:0] OP_CMP = 8'h31;
  localparam logic [7:0] OP_BMI = 8'h33;
  localparam logic [7:0] OP_BPL = 8'h34;
  localparam logic [7:0] OP_RET = 8'h41;
  localparam logic [7:0] OP_CAL = 8'h50;
  localparam logic [7:0] OP_HLT = 8'hFF;

  localparam logic MODE_LOAD = 1'b0;

  typedef enum logic [1:0] {
    STAT_EXEC    = 2'd0,
    STAT_HALT    = 2'd1,
    STAT_ILLEGAL = 2'd2,
    STAT_LOADED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OP,
    ST_B1,
    ST_B2,
    ST_EXEC,
    ST_WR2,
    ST_FIN
  } state_t;

endpackage

FILE: src/accumulator_cpu_core.sv
// Accumulator processor core: byte memory, sequencer and stream ports.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-----------------------------------------
//  s       | in  | s_tvalid/s_tready | s_tuser: mode; s_tdata: address, byte
//  m       | out | m_tvalid/m_tready | m_tuser: status; m_tdata: result
//
// A load writes its byte from ST_IDLE. A step runs ST_OP, then ST_FIN when
// stopped or on halt or an illegal opcode; else ST_B1, ST_B2 (not for a
// branch), ST_EXEC, ST_WR2 (store or call only) and ST_FIN (byte memory, one
// read and one write port). After rst the memory is cleared before s_tready
// rises. s_tready is high while no transaction is held; the result register
// lets a step run while a result waits on m_tready; a load waits for it.
module accumulator_cpu_core
  import acp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // load_address[15:0], load_byte[23:16]
  input  logic                  s_tuser,  // mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // fetch_address, opcode, accumulator,
                                          // zero_flag, negative_flag, stack_pointer,
                                          // retired_count, zero pad
  output logic [1:0]            m_tuser   // status
);

  logic [7:0] mem [MEM_DEPTH];

  state_t state, state_next;

  logic [ADDR_BITS-1:0] clr_addr;

  logic        buf_valid;
  logic        buf_mode;
  logic [15:0] buf_addr;
  logic [7:0]  buf_byte;

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic [1:0]            out_status;
  logic                  out_free;
  logic                  result_load;

  logic [15:0]        acc;
  logic [15:0]        pc;
  logic [15:0]        sp;
  logic               zf;
  logic               nf;
  logic [COUNT_W-1:0] count;
  status_t            run_status;
  status_t            status_reg;

  logic [15:0] fetch_pc;
  logic [7:0]  op_reg;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [15:0] wr2_addr;
  logic [7:0]  wr2_data;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [7:0]           mem_wdata;
  logic [ADDR_BITS-1:0] mem_raddr;
  logic [7:0]           rdata;

  logic [15:0] pc_p1, pc_p2, pc_p3, sp_p1, sp_m1, sp_m2, sp_p2;
  logic [15:0] w, add_res, sub_res, br_target, br_next;
  logic        op_legal, op_branch;

  assign pc_p1     = pc + 16'd1;
  assign pc_p2     = pc + 16'd2;
  assign pc_p3     = pc + 16'd3;
  assign sp_p1     = sp + 16'd1;
  assign sp_p2     = sp + 16'd2;
  assign sp_m1     = sp - 16'd1;
  assign sp_m2     = sp - 16'd2;
  assign w         = {b1, b2};
  assign add_res   = acc + w;
  assign sub_res   = acc - w;
  assign br_target = pc_p2 + {{8{b1[7]}}, b1};
  assign br_next   = ((op_reg == OP_BMI) == nf) ? br_target : pc_p2;
  assign op_branch = (op_reg == OP_BMI) || (op_reg == OP_BPL);

  always_comb begin
    unique case (rdata)
      OP_LDI, OP_ADD, OP_SUB, OP_STA, OP_CMP,
      OP_BMI, OP_BPL, OP_RET, OP_CAL: op_legal = 1'b1;
      default:                        op_legal = 1'b0;
    endcase
  end

  assign out_free    = !out_valid || m_tready;
  assign result_load = out_free &&
                       ((state == ST_IDLE && buf_valid && buf_mode == MODE_LOAD) ||
                        state == ST_FIN);
  assign s_tready    = !buf_valid && (state != ST_CLEAR);
  assign m_tvalid    = out_valid;
  assign m_tdata     = out_data;
  assign m_tuser     = out_status;

  // memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // next state and memory port control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = 8'd0;
    mem_raddr  = pc[ADDR_BITS-1:0];
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (buf_valid) begin
          if (buf_mode == MODE_LOAD) begin
            if (out_free) begin
              mem_we    = 1'b1;
              mem_waddr = buf_addr[ADDR_BITS-1:0];
              mem_wdata = buf_byte;
            end
          end else begin
            state_next = ST_OP;
          end
        end
      end
      ST_OP: begin
        if (run_status != STAT_EXEC || !op_legal) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_B1;
          mem_raddr  = (rdata == OP_RET) ? sp[ADDR_BITS-1:0] : pc_p1[ADDR_BITS-1:0];
        end
      end
      ST_B1: begin
        state_next = op_branch ? ST_EXEC : ST_B2;
        mem_raddr  = (op_reg == OP_RET) ? sp_p1[ADDR_BITS-1:0] : pc_p2[ADDR_BITS-1:0];
      end
      ST_B2: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_FIN;
        if (op_reg == OP_STA) begin
          mem_we     = 1'b1;
          mem_waddr  = w[ADDR_BITS-1:0];
          mem_wdata  = acc[15:8];
          state_next = ST_WR2;
        end else if (op_reg == OP_CAL) begin
          mem_we     = 1'b1;
          mem_waddr  = sp_m2[ADDR_BITS-1:0];
          mem_wdata  = pc_p3[15:8];
          state_next = ST_WR2;
        end
      end
      ST_WR2: begin
        mem_we     = 1'b1;
        mem_waddr  = wr2_addr[ADDR_BITS-1:0];
        mem_wdata  = wr2_data;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      buf_valid  <= 1'b0;
      out_valid  <= 1'b0;
      acc        <= 16'd0;
      pc         <= 16'd0;
      sp         <= STACK_RESET;
      zf         <= 1'b0;
      nf         <= 1'b0;
      count      <= '0;
      run_status <= STAT_EXEC;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      out_valid <= result_load || (out_valid && !m_tready);
      if (s_tvalid && s_tready) begin
        buf_valid <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (buf_valid && buf_mode == MODE_LOAD && out_free) begin
            buf_valid <= 1'b0;
          end
        end
        ST_OP: begin
          if (run_status == STAT_EXEC) begin
            if (rdata == OP_HLT) begin
              run_status <= STAT_HALT;
            end else if (!op_legal) begin
              run_status <= STAT_ILLEGAL;
            end
          end
        end
        ST_EXEC: begin
          count <= count + 1'b1;
          pc    <= pc_p3;
          unique case (op_reg)
            OP_LDI: begin
              acc <= w;
              zf  <= (w == 16'd0);
              nf  <= w[15];
            end
            OP_ADD: begin
              acc <= add_res;
              zf  <= (add_res == 16'd0);
              nf  <= add_res[15];
            end
            OP_SUB: begin
              acc <= sub_res;
              zf  <= (sub_res == 16'd0);
              nf  <= sub_res[15];
            end
            OP_CMP: begin
              zf <= (sub_res == 16'd0);
              nf <= sub_res[15];
            end
            OP_BMI, OP_BPL: begin
              pc <= br_next;
            end
            OP_RET: begin
              pc <= w;
              sp <= sp_p2;
            end
            OP_CAL: begin
              pc <= w;
              sp <= sp_m2;
            end
            default: ;
          endcase
        end
        ST_FIN: begin
          if (out_free) begin
            buf_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      buf_mode <= s_tuser;
      buf_addr <= s_tdata[15:0];
      buf_byte <= s_tdata[23:16];
    end
    unique case (state)
      ST_IDLE: begin
        fetch_pc <= pc;
        if (buf_valid && buf_mode == MODE_LOAD && out_free) begin
          out_status <= STAT_LOADED;
          out_data   <= {{OUT_PAD_W{1'b0}}, count, sp, nf, zf, acc, 8'd0, pc};
        end
      end
      ST_OP: begin
        op_reg <= rdata;
        if (run_status != STAT_EXEC) begin
          status_reg <= run_status;
        end else if (rdata == OP_HLT) begin
          status_reg <= STAT_HALT;
        end else if (!op_legal) begin
          status_reg <= STAT_ILLEGAL;
        end else begin
          status_reg <= STAT_EXEC;
        end
      end
      ST_B1: b1 <= rdata;
      ST_B2: b2 <= rdata;
      ST_EXEC: begin
        if (op_reg == OP_STA) begin
          wr2_addr <= w + 16'd1;
          wr2_data <= acc[7:0];
        end else begin
          wr2_addr <= sp_m1;
          wr2_data <= pc_p3[7:0];
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_status <= status_reg;
          out_data   <= {{OUT_PAD_W{1'b0}}, count, sp, nf, zf, acc, op_reg, fetch_pc};
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the accumulator processor core.
`timescale 1ns / 1ps

module tb_top
  import acp_pkg::*;
();

  localparam int IDLE_LIMIT   = 300000;
  localparam int ITEMS_TARGET = 540;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    status_t      status;
    logic [15:0]  fetch_address;
    logic [7:0]   opcode;
    logic [15:0]  accumulator;
    logic         zero_flag;
    logic         negative_flag;
    logic [15:0]  stack_pointer;
    logic [47:0]  retired_count;
  } core_result_t;

  class core_scoreboard;
    bit   [7:0]   mem [MEM_DEPTH];
    logic [15:0]  acc;
    logic [15:0]  pc;
    logic [15:0]  sp;
    logic         zf;
    logic         nf;
    logic [47:0]  retired;
    status_t      run_state;
    core_result_t expected [$];
    int           errors;

    function new();
      acc       = '0;
      pc        = '0;
      sp        = STACK_RESET;
      zf        = 1'b0;
      nf        = 1'b0;
      retired   = '0;
      run_state = STAT_EXEC;
      errors    = 0;
    endfunction

    function logic [7:0] rd8(logic [15:0] a);
      return mem[a[ADDR_BITS-1:0]];
    endfunction

    function void wr8(logic [15:0] a, logic [7:0] v);
      mem[a[ADDR_BITS-1:0]] = v;
    endfunction

    function logic [15:0] rd16(logic [15:0] a);
      return {rd8(a), rd8(a + 16'd1)};
    endfunction

    function void wr16(logic [15:0] a, logic [15:0] v);
      wr8(a, v[15:8]);
      wr8(a + 16'd1, v[7:0]);
    endfunction

    function void set_flags(logic [15:0] v);
      zf = (v == 16'd0);
      nf = v[15];
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // Advance the core state by one accepted transaction and queue its result.
    function void note_input(logic mode, logic [15:0] addr, logic [7:0] data);
      core_result_t r;
      status_t      st;
      logic [15:0]  pc0;
      logic [15:0]  npc;
      logic [15:0]  w;
      logic [15:0]  disp;
      logic [7:0]   disp_byte;
      logic [7:0]   op;
      pc0 = pc;
      op  = 8'h00;
      st  = STAT_EXEC;
      if (mode == MODE_LOAD) begin
        wr8(addr, data);
        st = STAT_LOADED;
      end else if (run_state != STAT_EXEC) begin
        op = rd8(pc0);
        st = run_state;
      end else begin
        op  = rd8(pc0);
        npc = pc0 + 16'd1;
        case (op)
          OP_LDI, OP_ADD, OP_SUB, OP_CMP, OP_STA, OP_CAL: begin
            w   = rd16(npc);
            npc = npc + 16'd2;
            case (op)
              OP_LDI: begin
                acc = w;
                set_flags(acc);
              end
              OP_ADD: begin
                acc = acc + w;
                set_flags(acc);
              end
              OP_SUB: begin
                acc = acc - w;
                set_flags(acc);
              end
              OP_CMP: set_flags(acc - w);
              OP_STA: wr16(w, acc);
              default: begin
                sp = sp - 16'd2;
                wr16(sp, npc);
                npc = w;
              end
            endcase
          end
          OP_BMI, OP_BPL: begin
            disp_byte = rd8(npc);
            disp = {{8{disp_byte[7]}}, disp_byte};
            npc  = npc + 16'd1;
            if ((op == OP_BMI) == nf) npc = npc + disp;
          end
          OP_RET: begin
            npc = rd16(sp);
            sp  = sp + 16'd2;
          end
          OP_HLT: st = STAT_HALT;
          default: st = STAT_ILLEGAL;
        endcase
        if (st == STAT_EXEC) begin
          pc      = npc;
          retired = retired + 48'd1;
        end else begin
          run_state = st;
        end
      end
      r.status        = st;
      r.fetch_address = pc0;
      r.opcode        = op;
      r.accumulator   = acc;
      r.zero_flag     = zf;
      r.negative_flag = nf;
      r.stack_pointer = sp;
      r.retired_count = retired;
      expected.push_back(r);
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0h, actual %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] status, logic [OUT_DATA_W-1:0] data);
      core_result_t want;
      if (expected.size() == 0) begin
        $error("result transaction with no expected result pending");
        errors++;
        return;
      end
      want = expected.pop_front();
      compare("status",        want.status,        status);
      compare("fetch_address", want.fetch_address, data[15:0]);
      compare("opcode",        want.opcode,        data[23:16]);
      compare("accumulator",   want.accumulator,   data[39:24]);
      compare("zero_flag",     want.zero_flag,     data[40]);
      compare("negative_flag", want.negative_flag, data[41]);
      compare("stack_pointer", want.stack_pointer, data[57:42]);
      compare("retired_count", want.retired_count, data[105:58]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;

  core_scoreboard sb;
  int             items_sent;
  int             burst_left;
  int             idle_cycles;

  accumulator_cpu_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata[15:0], s_tdata[23:16]);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result-side backpressure
  initial begin : rx_stall
    int hold;
    int r;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          m_tready <= 1'b1;
          hold = $urandom_range(0, 4);
        end else if (r < 85) begin
          m_tready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else if (r < 95) begin
          m_tready <= 1'b1;
          hold = $urandom_range(20, 80);
        end else begin
          m_tready <= 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit runnable(logic [7:0] op);
    case (op)
      OP_LDI, OP_ADD, OP_SUB, OP_CMP, OP_STA, OP_BMI, OP_BPL, OP_RET, OP_CAL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'h0001;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input logic mode, input logic [15:0] addr, input logic [7:0] data);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {data, addr};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_byte(input logic [15:0] addr, input logic [7:0] data);
    send_item(MODE_LOAD, addr, data);
  endtask

  task automatic step_core();
    send_item(~MODE_LOAD, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endtask

  // place one instruction at the program counter, then execute it
  task automatic put_instr(input logic [7:0] op, input logic [15:0] operand);
    logic [15:0] at;
    at = sb.pc;
    load_byte(at, op);
    case (op)
      OP_LDI, OP_ADD, OP_SUB, OP_CMP, OP_STA, OP_CAL: begin
        load_byte(at + 16'd1, operand[15:8]);
        load_byte(at + 16'd2, operand[7:0]);
      end
      OP_BMI, OP_BPL: load_byte(at + 16'd1, operand[7:0]);
      default: ;
    endcase
    step_core();
  endtask

  task automatic run_random();
    logic [7:0] ops [9];
    logic [7:0] op;
    int         r;
    ops = '{OP_LDI, OP_ADD, OP_SUB, OP_CMP, OP_STA, OP_BMI, OP_BPL, OP_CAL, OP_RET};
    while (items_sent < ITEMS_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        load_byte(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end else if (r < 35 && runnable(sb.rd8(sb.pc))) begin
        step_core();
      end else begin
        op = ops[$urandom_range(0, 8)];
        if (op == OP_BMI || op == OP_BPL) put_instr(op, 16'($urandom_range(0, 255)));
        else put_instr(op, pick_word());
      end
    end
  endtask

  // a halt or an illegal opcode, then steps and loads while stopped
  task automatic run_stop();
    logic [7:0] op;
    if ($urandom_range(0, 1) == 0) begin
      op = OP_HLT;
    end else begin
      do op = 8'($urandom_range(0, 255)); while (runnable(op) || op == OP_HLT);
    end
    put_instr(op, 16'h0000);
    step_core();
    load_byte(sb.pc, 8'($urandom_range(0, 255)));
    step_core();
    load_byte(sb.pc, OP_LDI);
    step_core();
    load_byte(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    step_core();
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    items_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    put_instr(OP_LDI, 16'hFFFF);
    put_instr(OP_ADD, 16'h0001);
    put_instr(OP_SUB, 16'h8000);
    put_instr(OP_CMP, 16'h8000);
    put_instr(OP_BMI, 16'h0005);  // not taken
    put_instr(OP_BPL, 16'h0080);  // taken, back 128 across address zero
    put_instr(OP_CAL, 16'hFFFF);  // operands of the callee wrap to 0x0000
    put_instr(OP_STA, 16'hFFFF);  // word store wraps
    put_instr(OP_RET, 16'h0000);

    run_random();
    run_stop();
    s_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/acp_pkg.sv
src/accumulator_cpu_core.sv
tb/tb_top.sv
